>>> rtl/bnfa_pkg.sv
// Shared constants, codes and the clear-bit search for the next-fit id allocator.
`timescale 1ns / 1ps
package bnfa_pkg;

  // Bitmap geometry
  localparam int unsigned MAP_WORDS = 16;
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned TOTAL_IDS = MAP_WORDS * WORD_BITS;
  localparam int unsigned WORD_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned PTR_W     = WORD_W + BIT_W;
  localparam int unsigned CNT_W     = $clog2(MAP_WORDS + 1);
  localparam int unsigned ID_W      = 10;

  // Request codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status codes
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef logic [WORD_BITS-1:0] map_word_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } hit_t;

  // Return the lowest set bit of a candidate vector
  function automatic hit_t first_set(input map_word_t vec);
    hit_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.found = 1'b1;
        res.idx   = BIT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

>>> rtl/bitmap_next_fit_allocator_unit.sv
// Next-fit identifier allocator over a bitmap, one map word scanned per cycle.
`timescale 1ns / 1ps
// Hands out ids from a bitmap of MAP_WORDS x 64 bits (1024 ids), cleared at
// reset; id 0 is never given out. Raise start_i with mode_i = 0 to allocate,
// mode_i = 1 to free id_to_free_i; a transaction is taken when start_i is
// high and busy_o is low. Every transaction gives one result on done_o for a
// single cycle, in the cycle after it finishes; the receiver cannot stall it, so
// it must sample granted_id_o and status_o while done_o is high. A free
// finishes in its accepting cycle and busy_o stays low. An allocation runs a
// scan that tests one 64-bit map word per cycle through one priority encoder,
// starting at the word under the next-fit pointer and wrapping back to it;
// busy_o is high throughout. status_o = 1 flags a full map.
module bitmap_next_fit_allocator_unit import bnfa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            mode_i,
  input  logic [ID_W-1:0] id_to_free_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [ID_W-1:0] granted_id_o,
  output logic            status_o
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_e;

  state_e            state_q, state_d;
  map_word_t         used_q [MAP_WORDS];
  map_word_t         used_d [MAP_WORDS];
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [ID_W-1:0]   gid_q, gid_d;
  logic              status_q, status_d;

  logic              accept;
  logic              free_ok;
  logic [WORD_W-1:0] free_word;
  map_word_t         scan_mask;
  map_word_t         cand;
  hit_t              hit;
  logic [PTR_W-1:0]  hit_id;
  logic [PTR_W:0]    hit_next;

  assign accept = start_i && (state_q == ST_IDLE);

  // Free request decode
  assign free_ok   = ({1'b0, id_to_free_i} < (ID_W + 1)'(TOTAL_IDS));
  assign free_word = id_to_free_i[BIT_W +: WORD_W];

  // Build the scan window: upper part of the start word first, all of the
  // following words, then the lower part of the start word last
  always_comb begin
    priority if (cnt_q == '0) begin
      scan_mask = ~map_word_t'(0) << ptr_q[BIT_W-1:0];
    end else if (cnt_q == CNT_W'(MAP_WORDS)) begin
      scan_mask = ~(~map_word_t'(0) << ptr_q[BIT_W-1:0]);
    end else begin
      scan_mask = ~map_word_t'(0);
    end
    // id 0 is never handed out
    if (word_q == '0) begin
      scan_mask[0] = 1'b0;
    end
  end

  assign cand     = ~used_q[word_q] & scan_mask;
  assign hit      = first_set(cand);
  assign hit_id   = {word_q, hit.idx};
  assign hit_next = {1'b0, hit_id} + (PTR_W + 1)'(1);

  // Next-state logic
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    ptr_d    = ptr_q;
    word_d   = word_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    gid_d    = gid_q;
    status_d = status_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (mode_i == MODE_FREE) begin
            if (free_ok) begin
              used_d[free_word][id_to_free_i[BIT_W-1:0]] = 1'b0;
            end
            done_d   = 1'b1;
            gid_d    = '0;
            status_d = STATUS_DONE;
          end else begin
            word_d  = ptr_q[PTR_W-1:BIT_W];
            cnt_d   = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (hit.found) begin
          used_d[word_q][hit.idx] = 1'b1;
          // advance the pointer, wrapping past the top to 1
          if (hit_next >= (PTR_W + 1)'(TOTAL_IDS)) begin
            ptr_d = PTR_W'(1);
          end else begin
            ptr_d = hit_next[PTR_W-1:0];
          end
          done_d   = 1'b1;
          gid_d    = ID_W'(hit_id);
          status_d = STATUS_DONE;
          state_d  = ST_IDLE;
        end else if (cnt_q == CNT_W'(MAP_WORDS)) begin
          done_d   = 1'b1;
          gid_d    = '0;
          status_d = STATUS_FULL;
          state_d  = ST_IDLE;
        end else begin
          if (word_q == WORD_W'(MAP_WORDS - 1)) begin
            word_d = '0;
          end else begin
            word_d = word_q + WORD_W'(1);
          end
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state, bitmap and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ptr_q    <= PTR_W'(1);
      word_q   <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      gid_q    <= '0;
      status_q <= STATUS_DONE;
      for (int w = 0; w < MAP_WORDS; w++) begin
        used_q[w] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      word_q   <= word_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      gid_q    <= gid_d;
      status_q <= status_d;
      used_q   <= used_d;
    end
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign granted_id_o = gid_q;
  assign status_o     = status_q;

endmodule
